// ===== rtl/core/box_filter_3x3_macros.svh =====
// Assertion helpers shared by the filter RTL.
`ifndef BOX_FILTER_3X3_MACROS_SVH
`define BOX_FILTER_3X3_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define BF3_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bf3 check failed in the same cycle");

// Check that cons holds in the cycle after ante.
`define BF3_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bf3 check failed one cycle later");

`endif

// ===== rtl/core/bf3_pkg.sv =====
`default_nettype none

package bf3_pkg;

   // Field widths
   localparam int PIX_W      = 8;
   localparam int ROW_W      = 10;
   localparam int MEAN_W     = 12;
   localparam int SIZE_W     = 11;
   localparam int SUM_W      = 12;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 32;

   // Defaults
   localparam int                MAX_SIZE_DEF = 1024;
   localparam logic [SIZE_W-1:0] SIZE_RESET   = 11'd1024;

   // floor(n / 9) = (n * RECIP_MUL) >> RECIP_SHIFT, exact for n * 5 < 2**20
   localparam int               RECIP_W     = 17;
   localparam logic [RECIP_W-1:0] RECIP_MUL = 17'd116509;
   localparam int               RECIP_SHIFT = 20;

   // Result kinds, in the order they leave for one pixel
   localparam logic [1:0] RK_CENTER = 2'd0;  // (r-1, c-1), full window
   localparam logic [1:0] RK_RIGHT  = 2'd1;  // (r-1, c), right edge flush
   localparam logic [1:0] RK_BOTTOM = 2'd2;  // (r, c-1), last row flush
   localparam logic [1:0] RK_CORNER = 2'd3;  // (r, c), bottom-right corner

   // Scale a window sum to 4 fraction bits and divide by 9
   function automatic logic [MEAN_W-1:0] mean_of(input logic [SUM_W-1:0] sum);
      logic [SUM_W+4+RECIP_W-1:0] prod;
      prod = (SUM_W+4+RECIP_W)'({sum, 4'b0000}) * (SUM_W+4+RECIP_W)'(RECIP_MUL);
      return prod[RECIP_SHIFT +: MEAN_W];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bf3_line_buf.sv =====
`default_nettype none

module bf3_line_buf #(
   parameter  int DEPTH = bf3_pkg::MAX_SIZE_DEF,
   localparam int AW    = $clog2(DEPTH)
) (
   input  wire logic                     clock,
   input  wire logic                     rd_en,
   input  wire logic [AW-1:0]            rd_addr,
   input  wire logic [bf3_pkg::PIX_W-1:0] push_pix,
   input  wire logic                     cp_en,
   input  wire logic [AW-1:0]            cp_addr,
   input  wire logic [bf3_pkg::PIX_W-1:0] cp_pix,
   output logic      [bf3_pkg::PIX_W-1:0] above_q,
   output logic      [bf3_pkg::PIX_W-1:0] two_q
);
   import bf3_pkg::*;

   logic [PIX_W-1:0] mem_above [DEPTH];
   logic [PIX_W-1:0] mem_two   [DEPTH];

   // Row above: read old value, then store the new pixel at the same column
   always_ff @(posedge clock) begin
      if (rd_en) begin
         above_q            <= mem_above[rd_addr];
         mem_above[rd_addr] <= push_pix;
      end
   end

   // Row two above: read at accept, copy the old row-above value when stage 1 advances
   always_ff @(posedge clock) begin
      if (rd_en) begin
         two_q <= mem_two[rd_addr];
      end
      if (cp_en) begin
         mem_two[cp_addr] <= cp_pix;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/box_filter_3x3.sv =====
`default_nettype none
`include "box_filter_3x3_macros.svh"

// 3x3 mean filter with zero padding over a square image of csr_wr_data by
// csr_wr_data pixels (clamped to 2..MAX_SIZE), taken in raster order one pixel
// per beat. Each result carries its row, column and floor(sum*16/9). One pixel
// is accepted per clock as long as each pixel gives at most one result and
// rsp_tready stays high; the last pixel of each row after the first gives two
// results and the last row's pixels up to four, and the input then waits while
// the extra results leave, since a single result register leaves one result per
// clock. rsp_tlast marks the final result caused by a pixel. An accepted pixel
// passes the line buffer read, the window update and the result register before
// its first result. The two line buffers are MAX_SIZE-deep memories with
// undefined contents after reset; rows above the image are masked, so no clearing
// pass is needed. Change the size only while no beat is in flight.
module box_filter_3x3 #(
   parameter int MAX_SIZE = bf3_pkg::MAX_SIZE_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_wr_en,
   input  wire logic [bf3_pkg::SIZE_W-1:0]     csr_wr_data,  // image_size
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [bf3_pkg::REQ_DATA_W-1:0] req_tdata,    // [7:0] pixel
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic      [bf3_pkg::RSP_DATA_W-1:0] rsp_tdata,    // [9:0] out_row,
                                                             // [19:10] out_col,
                                                             // [31:20] mean
   output logic                                rsp_tlast
);
   import bf3_pkg::*;

   localparam int AW = $clog2(MAX_SIZE);
   localparam int SW = AW + 1;
   localparam int CW = (SW > SIZE_W) ? SW : SIZE_W;
   localparam int EW = (AW > ROW_W) ? AW : ROW_W;

   // ---------------- configuration ----------------
   logic [SIZE_W-1:0] size_ff;
   logic [CW-1:0]     size_ext;
   logic [SW-1:0]     eff_size;
   logic [AW-1:0]     last_idx;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RESET;
      end else if (csr_wr_en) begin
         size_ff <= csr_wr_data;
      end
   end

   // Clamp the size to 2..MAX_SIZE
   always_comb begin
      size_ext = CW'(size_ff);
      if (size_ext < CW'(2)) begin
         eff_size = SW'(2);
      end else if (size_ext > CW'(MAX_SIZE)) begin
         eff_size = SW'(MAX_SIZE);
      end else begin
         eff_size = SW'(size_ext);
      end
      last_idx = AW'(eff_size - SW'(1));
   end

   // ---------------- position counters ----------------
   logic [AW-1:0] row_ff, col_ff, row_in, col_in;
   logic [AW-1:0] row_cur, col_cur;
   logic          out_of_range;
   logic          req_fire;

   assign req_fire = req_tvalid && req_tready;

   // Restart at the origin if the size shrank below the current position
   always_comb begin
      out_of_range = ({1'b0, row_ff} >= eff_size) || ({1'b0, col_ff} >= eff_size);
      row_cur      = out_of_range ? '0 : row_ff;
      col_cur      = out_of_range ? '0 : col_ff;
      if (col_cur == last_idx) begin
         col_in = '0;
         row_in = (row_cur == last_idx) ? '0 : row_cur + AW'(1);
      end else begin
         col_in = col_cur + AW'(1);
         row_in = row_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (req_fire) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // ---------------- stage 1: pixel and line buffer read ----------------
   logic             s1_valid_ff;
   logic [PIX_W-1:0] s1_pix_ff;
   logic [AW-1:0]    s1_row_ff, s1_col_ff;
   logic             s1_r_ge1_ff, s1_r_ge2_ff, s1_r_last_ff;
   logic             s1_c_ge1_ff, s1_c_last_ff;
   logic             s1_adv;
   logic             gen_free;
   logic [PIX_W-1:0] above_q, two_q;

   assign req_tready = !s1_valid_ff || gen_free;
   assign s1_adv     = s1_valid_ff && gen_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   // Latch the pixel and its position flags
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_pix_ff    <= req_tdata[PIX_W-1:0];
         s1_row_ff    <= row_cur;
         s1_col_ff    <= col_cur;
         s1_r_ge1_ff  <= (row_cur != '0);
         s1_r_ge2_ff  <= (row_cur >= AW'(2));
         s1_r_last_ff <= (row_cur == last_idx);
         s1_c_ge1_ff  <= (col_cur != '0);
         s1_c_last_ff <= (col_cur == last_idx);
      end
   end

   bf3_line_buf #(
      .DEPTH (MAX_SIZE)
   ) u_line_buf (
      .clock    (clock),
      .rd_en    (req_fire),
      .rd_addr  (col_cur),
      .push_pix (req_tdata[PIX_W-1:0]),
      .cp_en    (s1_adv),
      .cp_addr  (s1_col_ff),
      .cp_pix   (above_q),
      .above_q  (above_q),
      .two_q    (two_q)
   );

   // ---------------- window update and sums ----------------
   logic [PIX_W-1:0] win_ff [3][3];
   logic [PIX_W-1:0] win_in [3][3];
   logic [SUM_W-1:0] full_col [3];
   logic [SUM_W-1:0] low_col  [3];
   logic [SUM_W-1:0] sum_in   [4];
   logic [3:0]       mask_in;

   // Shift columns left, zero them at the row start, load the new column
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         win_in[i][0] = s1_c_ge1_ff ? win_ff[i][1] : '0;
         win_in[i][1] = s1_c_ge1_ff ? win_ff[i][2] : '0;
      end
      win_in[0][2] = s1_r_ge2_ff ? two_q : '0;
      win_in[1][2] = s1_r_ge1_ff ? above_q : '0;
      win_in[2][2] = s1_pix_ff;

      for (int j = 0; j < 3; j++) begin
         low_col[j]  = SUM_W'(win_in[1][j]) + SUM_W'(win_in[2][j]);
         full_col[j] = low_col[j] + SUM_W'(win_in[0][j]);
      end
      sum_in[RK_CENTER] = full_col[0] + full_col[1] + full_col[2];
      sum_in[RK_RIGHT]  = full_col[1] + full_col[2];
      sum_in[RK_BOTTOM] = low_col[0] + low_col[1] + low_col[2];
      sum_in[RK_CORNER] = low_col[1] + low_col[2];

      mask_in[RK_CENTER] = s1_r_ge1_ff  && s1_c_ge1_ff;
      mask_in[RK_RIGHT]  = s1_r_ge1_ff  && s1_c_last_ff;
      mask_in[RK_BOTTOM] = s1_r_last_ff && s1_c_ge1_ff;
      mask_in[RK_CORNER] = s1_r_last_ff && s1_c_last_ff;
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         win_ff <= win_in;
      end
   end

   // ---------------- stage 2: result sequencer ----------------
   logic [3:0]       gen_mask_ff;
   logic [SUM_W-1:0] gen_sum_ff [4];
   logic [AW-1:0]    gen_row_ff, gen_col_ff;
   logic             rsp_free, gen_emit;
   logic [1:0]       sel_kind;
   logic [3:0]       sel_bit, remain;
   logic [AW-1:0]    sel_row, sel_col;
   logic [EW-1:0]    sel_row_ext, sel_col_ext;

   assign rsp_free = !rsp_tvalid || rsp_tready;
   assign gen_emit = (gen_mask_ff != '0) && rsp_free;

   // Pick the lowest pending result and form its position
   always_comb begin
      if (gen_mask_ff[RK_CENTER]) begin
         sel_kind = RK_CENTER;
      end else if (gen_mask_ff[RK_RIGHT]) begin
         sel_kind = RK_RIGHT;
      end else if (gen_mask_ff[RK_BOTTOM]) begin
         sel_kind = RK_BOTTOM;
      end else begin
         sel_kind = RK_CORNER;
      end
      sel_bit = 4'b0001 << sel_kind;
      remain  = gen_mask_ff & ~sel_bit;

      unique case (sel_kind) inside
         RK_CENTER: begin
            sel_row = gen_row_ff - AW'(1);
            sel_col = gen_col_ff - AW'(1);
         end
         RK_RIGHT: begin
            sel_row = gen_row_ff - AW'(1);
            sel_col = gen_col_ff;
         end
         RK_BOTTOM: begin
            sel_row = gen_row_ff;
            sel_col = gen_col_ff - AW'(1);
         end
         default: begin
            sel_row = gen_row_ff;
            sel_col = gen_col_ff;
         end
      endcase
      sel_row_ext = EW'(sel_row);
      sel_col_ext = EW'(sel_col);
   end

   assign gen_free = (gen_mask_ff == '0) || (gen_emit && (remain == '0));

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_mask_ff <= '0;
      end else if (s1_adv) begin
         gen_mask_ff <= mask_in;
      end else if (gen_emit) begin
         gen_mask_ff <= remain;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         gen_sum_ff <= sum_in;
         gen_row_ff <= s1_row_ff;
         gen_col_ff <= s1_col_ff;
      end
   end

   // ---------------- result register ----------------
   logic              rsp_valid_ff;
   logic [ROW_W-1:0]  out_row_ff, out_col_ff;
   logic [MEAN_W-1:0] mean_ff;
   logic              last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (gen_emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (gen_emit) begin
         out_row_ff <= sel_row_ext[ROW_W-1:0];
         out_col_ff <= sel_col_ext[ROW_W-1:0];
         mean_ff    <= mean_of(gen_sum_ff[sel_kind]);
         last_ff    <= (remain == '0);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {mean_ff, out_col_ff, out_row_ff};
   assign rsp_tlast  = last_ff;

   // ---------------- checks ----------------
   `BF3_ASSERT_NEXT(a_emit_loads, clock, reset, gen_emit, rsp_valid_ff)
   `BF3_ASSERT_NEXT(a_col_moves, clock, reset, req_fire, col_ff != $past(col_cur))
   `BF3_ASSERT_NOW(a_no_overrun, clock, reset, s1_adv && (gen_mask_ff != '0), gen_emit)

endmodule

`default_nettype wire
